// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/shsc_pkg.sv
package shsc_pkg;

  localparam int PERIOD_WIDTH = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int PATTERN_W    = 24;
  localparam int STEP_COUNT   = 8;
  localparam int INDEX_W      = $clog2(STEP_COUNT);
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;

  localparam int PERIOD_RESET      = 469;
  localparam int MIN_PERIOD_RESET  = 250;
  localparam int MAX_PERIOD_RESET  = 8000;
  localparam int PERIOD_STEP_RESET = 155;

  // register index, from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MIN_PERIOD  = 2'd0,
    REG_MAX_PERIOD  = 2'd1,
    REG_PERIOD_STEP = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_BUTTON = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    BTN_SLOWER = 3'd1,
    BTN_TOGGLE = 3'd2,
    BTN_LEFT   = 3'd3,
    BTN_FASTER = 3'd4,
    BTN_RIGHT  = 3'd6
  } btn_code_e;

  typedef struct packed {
    logic       cmd;
    logic [2:0] buttons;
  } in_word_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] drive_pattern;
    logic                 stepped;
    logic                 running;
    logic                 dir_left;
    logic [CFG_WIDTH-1:0] step_period;
  } out_word_t;

  typedef logic [PATTERN_W-1:0] pattern_t;

  localparam pattern_t HALF_STEP_TABLE [STEP_COUNT] = '{
    24'h80C000, 24'h800000, 24'h110000, 24'h000000,
    24'h00E000, 24'h002000, 24'h912000, 24'h802000
  };

endpackage

// File: rtl/stepper_half_step_controller_core.sv
// Channel  Dir  Handshake                  Word
// in       in   in_valid_i / in_ready_o    shsc_pkg::in_word_t  (cmd, buttons)
// out      out  out_valid_o / out_ready_i  shsc_pkg::out_word_t (pattern, flags, period)
// cfg      in   APB psel/penable/pwrite    min_period, max_period, period_step
//
// One word per cycle sustained while out_ready_i holds: an accepted word sits in the
// input register, is resolved against the motor state in one combinational pass
// and lands in the result register once that register is free.
// Reset (rst_ni low, asynchronous) stops the motor, selects right, loads the
// default period and clears the counter and pattern; no clearing pass.
// A stalled output holds the result register; the input register then holds
// too and in_ready_o drops until out_ready_i returns.
`include "assert_macros.svh"

module stepper_half_step_controller_core #(
  parameter int PeriodWidth = shsc_pkg::PERIOD_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  shsc_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output shsc_pkg::out_word_t       out_word_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [shsc_pkg::APB_AW-1:0] paddr,
  input  logic [shsc_pkg::APB_DW-1:0] pwdata,
  output logic [shsc_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import shsc_pkg::*;

  // sum wide enough for period +/- step and a sign
  localparam int SumWidth = ((PeriodWidth > CFG_WIDTH) ? PeriodWidth : CFG_WIDTH) + 2;
  localparam logic [PeriodWidth-1:0] PeriodReset = PeriodWidth'(PERIOD_RESET);

  // ---------------- configuration registers ----------------
  logic [CFG_WIDTH-1:0] min_period_q, max_period_q, period_step_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q  <= CFG_WIDTH'(MIN_PERIOD_RESET);
      max_period_q  <= CFG_WIDTH'(MAX_PERIOD_RESET);
      period_step_q <= CFG_WIDTH'(PERIOD_STEP_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_PERIOD:  min_period_q  <= pwdata[CFG_WIDTH-1:0];
        REG_MAX_PERIOD:  max_period_q  <= pwdata[CFG_WIDTH-1:0];
        REG_PERIOD_STEP: period_step_q <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN_PERIOD:  prdata = APB_DW'(min_period_q);
      REG_MAX_PERIOD:  prdata = APB_DW'(max_period_q);
      REG_PERIOD_STEP: prdata = APB_DW'(period_step_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic     in_valid_q, out_valid_q;
  in_word_t in_word_q;
  logic     advance;

  // word in the input register moves on when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_word_q <= in_word_i;
  end

  // ---------------- motor state ----------------
  logic [PeriodWidth-1:0] tick_q, tick_d;
  logic [PeriodWidth-1:0] period_q, period_d;
  logic [INDEX_W-1:0]     index_q, index_d;
  logic                   run_q, run_d;
  logic                   left_q, left_d;
  pattern_t               pattern_q, pattern_d;
  logic                   stepped;

  // period adjust with clamp, min tested first
  logic                          slower;
  logic signed [SumWidth-1:0]    period_ext, step_ext, min_ext, max_ext, period_sum;
  logic [PeriodWidth-1:0]        period_adj;
  logic [PeriodWidth-1:0]        tick_inc;

  always_comb begin
    slower     = (in_word_q.buttons == BTN_SLOWER);
    period_ext = $signed(SumWidth'(period_q));
    step_ext   = $signed(SumWidth'(period_step_q));
    min_ext    = $signed(SumWidth'(min_period_q));
    max_ext    = $signed(SumWidth'(max_period_q));
    period_sum = slower ? (period_ext + step_ext) : (period_ext - step_ext);
    if (period_sum < min_ext) begin
      period_adj = PeriodWidth'(min_period_q);
    end else if (period_sum > max_ext) begin
      period_adj = PeriodWidth'(max_period_q);
    end else begin
      period_adj = period_sum[PeriodWidth-1:0];
    end
  end

  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    tick_d    = tick_q;
    period_d  = period_q;
    index_d   = index_q;
    run_d     = run_q;
    left_d    = left_q;
    pattern_d = pattern_q;
    stepped   = 1'b0;
    if (in_word_q.cmd == CMD_TICK) begin
      if (run_q) begin
        tick_d = tick_inc;
        if (tick_inc >= period_q) begin
          tick_d    = '0;
          index_d   = left_q ? (index_q - 1'b1) : (index_q + 1'b1);
          pattern_d = HALF_STEP_TABLE[index_d];
          stepped   = 1'b1;
        end
      end
    end else begin
      case (in_word_q.buttons)
        BTN_SLOWER, BTN_FASTER: period_d = period_adj;
        BTN_TOGGLE: begin
          run_d = !run_q;
          if (!run_q) tick_d = '0;
        end
        BTN_LEFT:  left_d = 1'b1;
        BTN_RIGHT: left_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      period_q  <= PeriodReset;
      index_q   <= '0;
      run_q     <= 1'b0;
      left_q    <= 1'b0;
      pattern_q <= '0;
    end else if (advance) begin
      tick_q    <= tick_d;
      period_q  <= period_d;
      index_q   <= index_d;
      run_q     <= run_d;
      left_q    <= left_d;
      pattern_q <= pattern_d;
    end
  end

  // ---------------- result register ----------------
  out_word_t out_word_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q.drive_pattern <= pattern_d;
      out_word_q.stepped       <= stepped;
      out_word_q.running       <= run_d;
      out_word_q.dir_left      <= left_d;
      out_word_q.step_period   <= CFG_WIDTH'(period_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------- checks ----------------
  `ASSERT_RST(a_step_needs_run, out_valid_o && out_word_o.stepped |-> out_word_o.running, "step reported while stopped")
  `ASSERT_RST(a_step_pattern, out_valid_o && out_word_o.stepped && !$past(advance) |-> out_word_o.drive_pattern == HALF_STEP_TABLE[index_q], "pattern does not match step index")
  `ASSERT_RST(a_stall_cause, !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i, "input stalled without output back-pressure")

endmodule

// File: test/tb_top.sv
module tb_top;
  import shsc_pkg::*;

  // One queued stimulus word; drain asks the driver to wait until every
  // word already sent has come back before this one goes out.
  typedef struct {
    in_word_t word;
    bit       drain;
  } stim_t;

  // Half-step pin patterns, index 0 to 7.
  localparam logic [PATTERN_W-1:0] PIN_PATTERNS [STEP_COUNT] = '{
    24'h80C000, 24'h800000, 24'h110000, 24'h000000,
    24'h00E000, 24'h002000, 24'h912000, 24'h802000
  };

  localparam int MAX_PRINTED = 40;   // mismatch lines printed, all are counted

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_word_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [APB_AW-1:0]    paddr       = '0;
  logic [APB_DW-1:0]    pwdata      = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  stepper_half_step_controller_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Motor model: own copy of the controller state and its three registers
  // ---------------------------------------------------------------------------
  logic [PERIOD_WIDTH-1:0] tick_cnt   = '0;
  logic [PERIOD_WIDTH-1:0] period_cur = PERIOD_WIDTH'(PERIOD_RESET);
  logic [INDEX_W-1:0]      step_idx   = '0;
  logic                    motor_on   = 1'b0;
  logic                    turn_left  = 1'b0;
  logic [PATTERN_W-1:0]    pins_cur   = '0;

  logic [CFG_WIDTH-1:0]    cfg_min    = CFG_WIDTH'(MIN_PERIOD_RESET);
  logic [CFG_WIDTH-1:0]    cfg_max    = CFG_WIDTH'(MAX_PERIOD_RESET);
  logic [CFG_WIDTH-1:0]    cfg_stride = CFG_WIDTH'(PERIOD_STEP_RESET);

  // Lower bound is tested first, so with min above max a value below min
  // lands on min and anything else above max lands on max.
  function automatic logic [PERIOD_WIDTH-1:0] clamp_period(int want);
    int lo;
    int hi;
    lo = int'(cfg_min);
    hi = int'(cfg_max);
    if (want < lo) return PERIOD_WIDTH'(cfg_min);
    else if (want > hi) return PERIOD_WIDTH'(cfg_max);
    return want[PERIOD_WIDTH-1:0];
  endfunction

  // Advances the motor model by one input word and returns the result word.
  function automatic out_word_t motor_step(in_word_t w);
    out_word_t r;
    logic      moved;
    moved = 1'b0;
    if (w.cmd == CMD_TICK) begin
      // ticks only count while running; buttons field is don't-care here
      if (motor_on) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= period_cur) begin
          tick_cnt = '0;
          step_idx = turn_left ? step_idx - 1'b1 : step_idx + 1'b1;
          pins_cur = PIN_PATTERNS[step_idx];
          moved    = 1'b1;
        end
      end
    end else begin
      case (w.buttons)
        BTN_SLOWER: period_cur = clamp_period(int'(period_cur) + int'(cfg_stride));
        BTN_FASTER: period_cur = clamp_period(int'(period_cur) - int'(cfg_stride));
        BTN_TOGGLE: begin
          // start clears the counter, stop leaves it alone
          if (motor_on) begin
            motor_on = 1'b0;
          end else begin
            motor_on = 1'b1;
            tick_cnt = '0;
          end
        end
        BTN_LEFT:   turn_left = 1'b1;
        BTN_RIGHT:  turn_left = 1'b0;
        default:    ;  // codes 0, 5 and 7 do nothing
      endcase
    end
    r.drive_pattern = pins_cur;
    r.stepped       = moved;
    r.running       = motor_on;
    r.dir_left      = turn_left;
    r.step_period   = CFG_WIDTH'(period_cur);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  stim_t     word_pending[$];     // words waiting for the driver
  out_word_t expected_words[$];   // predicted results, oldest first
  int        words_in     = 0;    // accepted input words (updated with NBA)
  int        words_out    = 0;    // accepted result words (updated with NBA)
  int        errors       = 0;
  int        steps_seen   = 0;
  int        button_words = 0;
  int        settings     = 1;    // reset values count as the first setting
  int        idle_pct     = 0;    // sender gap chance per cycle
  int        stall_pct    = 0;    // receiver stall chance per cycle

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending word once the current one is taken.
  // A drain word is held back until nothing is in flight.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    stim_t nxt;
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (word_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
          !(word_pending[0].drain && (in_valid_i || words_in != words_out))) begin
        nxt = word_pending.pop_front();
        in_word_i  <= nxt.word;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input word, checks every accepted
  // result word against the oldest prediction, and drives the stall pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      if (in_valid_i && in_ready_o) begin
        want = motor_step(in_word_i);
        if (want.stepped) steps_seen++;
        if (in_word_i.cmd == CMD_BUTTON) button_words++;
        expected_words.push_back(want);
        words_in <= words_in + 1;
      end
      if (out_valid_o && out_ready_i) begin
        words_out <= words_out + 1;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", 64'(out_word_o), 64'(0));
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.drive_pattern !== want.drive_pattern)
            report_mismatch("drive_pattern", 64'(out_word_o.drive_pattern),
                            64'(want.drive_pattern));
          if (out_word_o.stepped !== want.stepped)
            report_mismatch("stepped", 64'(out_word_o.stepped), 64'(want.stepped));
          if (out_word_o.running !== want.running)
            report_mismatch("running", 64'(out_word_o.running), 64'(want.running));
          if (out_word_o.dir_left !== want.dir_left)
            report_mismatch("dir_left", 64'(out_word_o.dir_left), 64'(want.dir_left));
          if (out_word_o.step_period !== want.step_period)
            report_mismatch("step_period", 64'(out_word_o.step_period),
                            64'(want.step_period));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(cmd_e c, logic [2:0] b);
    stim_t s;
    s.word.cmd     = c;
    s.word.buttons = b;
    s.drain        = 1'b0;
    word_pending.push_back(s);
  endtask

  // Mostly ticks with a running motor and speed/direction changes mixed in;
  // toggles are kept rare so the motor runs for long stretches. A share of
  // button words carry any code at all, the ignored ones included.
  function automatic stim_t random_word();
    stim_t s;
    int    r;
    s.drain        = 1'b0;
    s.word.buttons = 3'($urandom_range(0, 7));
    s.word.cmd     = CMD_TICK;
    if ($urandom_range(0, 99) >= 62) begin
      s.word.cmd = CMD_BUTTON;
      r = $urandom_range(0, 99);
      if (r < 5)       s.word.buttons = BTN_TOGGLE;
      else if (r < 28) s.word.buttons = BTN_SLOWER;
      else if (r < 51) s.word.buttons = BTN_FASTER;
      else if (r < 63) s.word.buttons = BTN_LEFT;
      else if (r < 75) s.word.buttons = BTN_RIGHT;
    end
    return s;
  endfunction

  // Waits until every sent word has come back, then lets the pipe settle.
  // Sampled on the falling edge so the driver's updates have all landed.
  task automatic wait_drained();
    while (word_pending.size() != 0 || in_valid_i || words_in != words_out)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access; the register loads on the access edge.
  task automatic write_reg(reg_idx_e idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DW-CFG_WIDTH){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_PERIOD:  cfg_min    = val;
      REG_MAX_PERIOD:  cfg_max    = val;
      REG_PERIOD_STEP: cfg_stride = val;
      default:         ;
    endcase
  endtask

  // Only called with the block idle: nothing pending and nothing in flight.
  task automatic set_periods(int lo, int hi, int stride);
    write_reg(REG_MIN_PERIOD, CFG_WIDTH'(lo));
    write_reg(REG_MAX_PERIOD, CFG_WIDTH'(hi));
    write_reg(REG_PERIOD_STEP, CFG_WIDTH'(stride));
    settings++;
  endtask

  // Random batch under one flow-control mix; restarts the motor first if it
  // was left stopped, and every so often holds a word until the pipe is empty.
  task automatic run_random(int idle, int stall, int n);
    stim_t s;
    idle_pct  = idle;
    stall_pct = stall;
    if (!motor_on) push_word(CMD_BUTTON, BTN_TOGGLE);
    for (int i = 0; i < n; i++) begin
      s = random_word();
      s.drain = (i % 97 == 50);
      word_pending.push_back(s);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: ignored codes, a tick while stopped, speed presses down
    // to the lower clamp, start/stop and a tick after stop.
    push_word(CMD_BUTTON, 3'd0);
    push_word(CMD_BUTTON, 3'd5);
    push_word(CMD_BUTTON, 3'd7);
    push_word(CMD_TICK,   3'd7);
    push_word(CMD_BUTTON, BTN_SLOWER);
    push_word(CMD_BUTTON, BTN_FASTER);
    push_word(CMD_BUTTON, BTN_FASTER);
    push_word(CMD_BUTTON, BTN_FASTER);
    push_word(CMD_BUTTON, BTN_TOGGLE);
    push_word(CMD_TICK,   3'd0);
    push_word(CMD_BUTTON, BTN_TOGGLE);
    push_word(CMD_TICK,   3'd2);
    wait_drained();

    // Tiny periods: upper clamp from far above, lower clamp, a step on every
    // tick and the index wrapping from 0 to 7 when turning left.
    set_periods(1, 6, 3);
    push_word(CMD_BUTTON, BTN_SLOWER);
    push_word(CMD_BUTTON, BTN_FASTER);
    push_word(CMD_BUTTON, BTN_FASTER);
    push_word(CMD_BUTTON, BTN_TOGGLE);
    push_word(CMD_BUTTON, BTN_LEFT);
    push_word(CMD_TICK,   3'd0);
    push_word(CMD_TICK,   3'd5);
    push_word(CMD_BUTTON, BTN_RIGHT);
    push_word(CMD_TICK,   3'd0);
    push_word(CMD_TICK,   3'd0);
    wait_drained();
    run_random(0, 0, 300);

    // Extremes: full range with the largest stride, period flips 1 <-> 65535.
    set_periods(1, 65535, 65535);
    run_random(55, 0, 300);

    // Min above max with zero stride: the clamp order decides the period.
    set_periods(65535, 1, 0);
    run_random(0, 55, 300);

    // Moderate small periods with both sides idling now and then.
    set_periods(2, 12, 3);
    run_random(12, 12, 300);

    if (expected_words.size() != 0)
      report_mismatch("results never delivered", 64'(expected_words.size()), 64'(0));

    $display("Covered %0d words (%0d button events, %0d steps) over %0d period settings",
             words_in, button_words, steps_seen, settings);
    $display("and four flow-control mixes, %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: stepper_half_step_controller_core.f
+incdir+rtl
rtl/shsc_pkg.sv
rtl/stepper_half_step_controller_core.sv
test/tb_top.sv
